[sv/chiptune_waveform_oscillator_assert.svh]
// assertion macros for the chiptune waveform oscillator checker
// used by the checker file; needs clk_i and rst_ni in the including scope
`ifndef CHIPTUNE_WAVEFORM_OSCILLATOR_ASSERT_SVH
`define CHIPTUNE_WAVEFORM_OSCILLATOR_ASSERT_SVH

// same-cycle implication, off during reset
`define CWO_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define CWO_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/cwo_pkg.sv]
// shared types, constants and elaboration-time table functions
// of the chiptune waveform oscillator; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package cwo_pkg;

  // tone and table constants
  localparam int ROOT_FREQ_HZ    = 440;
  localparam int SAMPLE_RATE_HZ  = 44100;
  localparam int PHASE_FRAC_BITS = 24;
  localparam int SINE_TABLE_BITS = 10;
  localparam int SINE_QUARTER    = 1 << (SINE_TABLE_BITS - 2);

  localparam longint Q30_ONE        = 64'sd1073741824;
  localparam longint TWO_PI_Q30     = 64'sd6746518852;
  localparam int     FOUR_PI_SQ_W   = 30;
  localparam logic [FOUR_PI_SQ_W-1:0] FOUR_PI_SQ_Q24 = 30'd662337940;

  // sample and register widths
  localparam int SAMPLE_W    = 16;
  localparam int MAG_W       = 15;
  localparam int WAVE_W      = 3;
  localparam int SEMI_W      = 7;
  localparam int GAIN_W      = 16;
  localparam int COUNT_W     = 21;
  localparam int LFSR_W      = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 21;
  localparam int IN_TDATA_W  = 8;
  localparam int NOISE_P_W   = 25;

  localparam logic [LFSR_W-1:0]  LFSR_SEED  = 16'hACE1;
  localparam logic [LFSR_W-1:0]  LFSR_TAPS  = 16'hB400;
  localparam logic [MAG_W-1:0]   FULL_SCALE = 15'd32767;

  // register reset values
  localparam logic [WAVE_W-1:0]  WAVE_RST  = 3'd1;
  localparam logic [SEMI_W-1:0]  SEMI_RST  = 7'd3;
  localparam logic [GAIN_W-1:0]  GAIN_RST  = 16'd4096;
  localparam logic [COUNT_W-1:0] COUNT_RST = 21'd132300;

  // waveform codes; every other code selects the cubic-sine noise
  localparam logic [WAVE_W-1:0] WAVE_SQUARE   = 3'd1;
  localparam logic [WAVE_W-1:0] WAVE_TRIANGLE = 3'd2;
  localparam logic [WAVE_W-1:0] WAVE_SINE     = 3'd3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WAVEFORM_TYPE   = 2'd0,
    CFG_SEMITONE_OFFSET = 2'd1,
    CFG_VOLUME_GAIN     = 2'd2,
    CFG_SAMPLE_COUNT    = 2'd3
  } cfg_idx_e;

  // operand pairs of the shared multiplier
  typedef enum logic [2:0] {
    MUL_P2    = 3'd0,
    MUL_P3    = 3'd1,
    MUL_TURNS = 3'd2,
    MUL_TRI   = 3'd3,
    MUL_GAIN  = 3'd4
  } mul_sel_e;

  // controller to datapath
  typedef struct packed {
    logic     start;
    logic     check;
    logic     mul_en;
    mul_sel_e mul_sel;
    logic     rom_rd;
    logic     update;
    logic     out_ld;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic silent;
  } status_t;

  // 2^(k/12) in UQ1.16, i.e. scaled by 2^16
  function automatic longint semi_ratio(int k);
    longint r;
    case (k)
      0:       r = 65536;
      1:       r = 69433;
      2:       r = 73562;
      3:       r = 77935;
      4:       r = 82570;
      5:       r = 87480;
      6:       r = 92682;
      7:       r = 98193;
      8:       r = 104032;
      9:       r = 110218;
      10:      r = 116772;
      default: r = 123715;
    endcase
    return r;
  endfunction

  // phase step for a signed semitone offset, evaluated at elaboration
  function automatic longint calc_step(int v, int pfb);
    int     oct;
    int     k;
    longint num;
    longint q;
    longint rem;
    longint full;
    oct  = (v + 72) / 12 - 6;
    k    = (v + 72) % 12;
    num  = longint'(ROOT_FREQ_HZ) * semi_ratio(k);
    q    = num / SAMPLE_RATE_HZ;
    rem  = num % SAMPLE_RATE_HZ;
    full = (q << pfb) + ((rem << pfb) / SAMPLE_RATE_HZ);
    return full >>> (16 - oct);
  endfunction

  // sin(x) in Q30 for x in [0, pi/2], truncated Taylor series
  function automatic longint sin_q30(longint x);
    longint x2;
    longint t;
    x2 = (x * x) >>> 30;
    t  = Q30_ONE;
    t  = Q30_ONE - ((x2 * t) >>> 30) / 110;
    t  = Q30_ONE - ((x2 * t) >>> 30) / 72;
    t  = Q30_ONE - ((x2 * t) >>> 30) / 42;
    t  = Q30_ONE - ((x2 * t) >>> 30) / 20;
    t  = Q30_ONE - ((x2 * t) >>> 30) / 6;
    return (x * t) >>> 30;
  endfunction

  // magnitude of one quarter-wave entry, round(32767*sin)
  function automatic logic [MAG_W-1:0] sine_q_entry(int q);
    longint x;
    longint s;
    x = (TWO_PI_Q30 * longint'(q)) >>> SINE_TABLE_BITS;
    s = (sin_q30(x) * 32767 + (longint'(1) << 29)) >>> 30;
    return MAG_W'(s);
  endfunction

endpackage

`default_nettype wire

[sv/cwo_sine_rom.sv]
// quarter-wave sine magnitude table with registered read
// depends on cwo_pkg for the table size and entry function
`timescale 1ns / 1ps
`default_nettype none

module cwo_sine_rom (
  input  logic                                clk_i,
  input  logic                                rd_en_i,
  input  logic [cwo_pkg::SINE_TABLE_BITS-2:0] addr_i,
  output logic [cwo_pkg::MAG_W-1:0]           data_o
);
  import cwo_pkg::*;

  logic [MAG_W-1:0] rom [SINE_QUARTER+1];
  logic [MAG_W-1:0] data_q;

  // entries from zero up to and including the quarter turn
  for (genvar g = 0; g <= SINE_QUARTER; g++) begin : g_entry
    assign rom[g] = sine_q_entry(g);
  end

  // registered read
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      data_q <= rom[addr_i];
    end
  end

  assign data_o = data_q;

endmodule

`default_nettype wire

[sv/cwo_ctrl.sv]
// sequencing state machine of the chiptune waveform oscillator
// depends on cwo_pkg for the command and status structs
`timescale 1ns / 1ps
`default_nettype none

module cwo_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_tvalid_i,
  output logic              s_tready_o,
  output logic              m_tvalid_o,
  input  logic              m_tready_i,
  input  cwo_pkg::status_t  status_i,
  output cwo_pkg::cmd_t     cmd_o
);
  import cwo_pkg::*;

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_CHECK  = 8'b0000_0010,
    ST_NOISE2 = 8'b0000_0100,
    ST_NOISE3 = 8'b0000_1000,
    ST_TABLE  = 8'b0001_0000,
    ST_SHAPE  = 8'b0010_0000,
    ST_GAIN   = 8'b0100_0000,
    ST_OUT    = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;
  logic   m_tvalid_q, m_tvalid_d;
  logic   out_free;

  assign out_free = !m_tvalid_q || m_tready_i;

  // next state and commands
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    cmd_o.mul_sel = MUL_P2;
    s_tready_o  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_tready_o = 1'b1;
        if (s_tvalid_i) begin
          cmd_o.start = 1'b1;
          state_d     = ST_CHECK;
        end
      end
      ST_CHECK: begin
        cmd_o.check   = 1'b1;
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_P2;
        state_d       = status_i.silent ? ST_OUT : ST_NOISE2;
      end
      ST_NOISE2: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_P3;
        state_d       = ST_NOISE3;
      end
      ST_NOISE3: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_TURNS;
        state_d       = ST_TABLE;
      end
      ST_TABLE: begin
        cmd_o.rom_rd  = 1'b1;
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_TRI;
        state_d       = ST_SHAPE;
      end
      ST_SHAPE: begin
        cmd_o.update = 1'b1;
        state_d      = ST_GAIN;
      end
      ST_GAIN: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_GAIN;
        state_d       = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) begin
          cmd_o.out_ld = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // output valid flag of the result register
  always_comb begin
    m_tvalid_d = m_tvalid_q;
    if (cmd_o.out_ld) begin
      m_tvalid_d = 1'b1;
    end else if (m_tready_i) begin
      m_tvalid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      m_tvalid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      m_tvalid_q <= m_tvalid_d;
    end
  end

  assign m_tvalid_o = m_tvalid_q;

endmodule

`default_nettype wire

[sv/cwo_dpath.sv]
// datapath: config registers, phase accumulator, noise lfsr, shared
// multiplier, sine table, gain and saturation; uses cwo_pkg and cwo_sine_rom
`timescale 1ns / 1ps
`default_nettype none

module cwo_dpath #(
  parameter int PhaseFracBits = cwo_pkg::PHASE_FRAC_BITS
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [cwo_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [cwo_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  input  logic                            restart_i,
  input  cwo_pkg::cmd_t                   cmd_i,
  output cwo_pkg::status_t                status_o,
  output logic [cwo_pkg::SAMPLE_W-1:0]    sample_o,
  output logic                            last_o
);
  import cwo_pkg::*;

  localparam int PW  = PhaseFracBits + 1;
  localparam int TW  = PW + 3;
  localparam int MA  = (PW > FOUR_PI_SQ_W) ? PW : FOUR_PI_SQ_W;
  localparam int PRW = MA + NOISE_P_W;
  localparam int SB  = SINE_TABLE_BITS;
  localparam logic [PW:0]   PH_ONE  = (PW+1)'(1) << PhaseFracBits;
  localparam logic [PW-1:0] PH_HALF = PW'(1) << (PhaseFracBits - 1);

  // configuration registers
  logic [WAVE_W-1:0]  wave_q;
  logic [SEMI_W-1:0]  semi_q;
  logic [GAIN_W-1:0]  gain_q;
  logic [COUNT_W-1:0] count_q;

  // run state
  logic [PW-1:0]      phase_q, phase_d;
  logic [COUNT_W-1:0] idx_q;
  logic [LFSR_W-1:0]  lfsr_q, lfsr_next;
  logic               done_q;
  logic               silent_q;

  // payload
  logic [PRW-1:0]     prod_q;
  logic               rom_neg_q;
  logic               shp_neg_q;
  logic [MAG_W-1:0]   shp_mag_q;
  logic               last_q;
  logic [SAMPLE_W-1:0] out_data_q;
  logic               out_last_q;

  logic [PW-1:0]      step_tab [1 << SEMI_W];
  logic [PW-1:0]      step;
  logic [PW:0]        phase_sum;
  logic [COUNT_W:0]   idx_inc;
  logic               silent;
  logic               last;
  logic               reseed;

  logic [NOISE_P_W-1:0] p24;
  logic [TW-1:0]        tri_a;
  logic                 tri_neg;
  logic [PW-1:0]        tri_mag;
  logic [MA-1:0]        mul_a;
  logic [NOISE_P_W-1:0] mul_b;

  logic [SB-1:0]        tab_idx;
  logic [SB-2:0]        rom_addr;
  logic [MAG_W-1:0]     rom_data;

  logic                 shape_neg;
  logic [MAG_W-1:0]     shape_mag;
  logic [19:0]          gain_mag;
  logic [SAMPLE_W-1:0]  sat_val;

  // phase step per semitone code, built at elaboration
  for (genvar g = 0; g < (1 << SEMI_W); g++) begin : g_step
    assign step_tab[g] = PW'(calc_step((g >= (1 << (SEMI_W - 1))) ?
                                       g - (1 << SEMI_W) : g, PhaseFracBits));
  end

  assign step = step_tab[semi_q];

  // phase aligned to 24 fraction bits for the noise shape
  if (PhaseFracBits >= 24) begin : g_p24_shr
    assign p24 = NOISE_P_W'(phase_q >> (PhaseFracBits - 24));
  end else begin : g_p24_shl
    assign p24 = NOISE_P_W'({phase_q, {(24 - PhaseFracBits){1'b0}}});
  end

  // triangle in sign and magnitude
  always_comb begin
    if (phase_q < PH_HALF) begin
      tri_a = TW'({phase_q, 2'b00}) - TW'(PH_ONE);
    end else begin
      tri_a = TW'(3) * TW'(PH_ONE) - TW'({phase_q, 2'b00});
    end
    tri_neg = tri_a[TW-1];
    tri_mag = tri_neg ? PW'(-tri_a) : PW'(tri_a);
  end

  // shared multiplier operands
  always_comb begin
    case (cmd_i.mul_sel)
      MUL_P2: begin
        mul_a = MA'(p24);
        mul_b = p24;
      end
      MUL_P3: begin
        mul_a = MA'(prod_q[48:24]);
        mul_b = p24;
      end
      MUL_TURNS: begin
        mul_a = MA'(FOUR_PI_SQ_Q24);
        mul_b = prod_q[48:24];
      end
      MUL_TRI: begin
        mul_a = MA'(tri_mag);
        mul_b = NOISE_P_W'(FULL_SCALE);
      end
      MUL_GAIN: begin
        mul_a = MA'(shp_mag_q);
        mul_b = NOISE_P_W'(gain_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // sine table address: phase for the sine, angle fraction for the noise
  always_comb begin
    if (wave_q == WAVE_SINE) begin
      tab_idx = phase_q[PhaseFracBits-1 -: SB];
    end else begin
      tab_idx = prod_q[47 -: SB];
    end
    if (tab_idx[SB-2]) begin
      rom_addr = (SB-1)'(SINE_QUARTER) - {1'b0, tab_idx[SB-3:0]};
    end else begin
      rom_addr = {1'b0, tab_idx[SB-3:0]};
    end
  end

  cwo_sine_rom u_sine_rom (
    .clk_i   (clk_i),
    .rd_en_i (cmd_i.rom_rd),
    .addr_i  (rom_addr),
    .data_o  (rom_data)
  );

  // shape selection
  always_comb begin
    case (wave_q)
      WAVE_SQUARE: begin
        shape_neg = phase_q < PH_HALF;
        shape_mag = FULL_SCALE;
      end
      WAVE_TRIANGLE: begin
        shape_neg = tri_neg;
        shape_mag = prod_q[PhaseFracBits +: MAG_W];
      end
      default: begin
        shape_neg = rom_neg_q;
        shape_mag = rom_data;
      end
    endcase
  end

  // run bookkeeping and next phase
  assign silent    = done_q || (idx_q >= count_q);
  assign idx_inc   = (COUNT_W+1)'(idx_q) + (COUNT_W+1)'(1);
  assign last      = idx_inc >= (COUNT_W+1)'(count_q);
  assign phase_sum = (PW+1)'(phase_q) + (PW+1)'(step);
  assign reseed    = (wave_q > WAVE_SINE) && (idx_q[5:0] == 6'd0);
  assign lfsr_next = lfsr_q[0] ? ((lfsr_q >> 1) ^ LFSR_TAPS) : (lfsr_q >> 1);

  always_comb begin
    if (reseed) begin
      phase_d = PW'(lfsr_next[6:0]) << (PhaseFracBits - 7);
    end else if (phase_sum > PH_ONE) begin
      phase_d = '0;
    end else begin
      phase_d = PW'(phase_sum);
    end
  end

  // gain and saturation
  assign gain_mag = prod_q[31:12];
  always_comb begin
    if (shp_neg_q) begin
      sat_val = (gain_mag > 20'd32768) ? 16'h8000 : -gain_mag[SAMPLE_W-1:0];
    end else begin
      sat_val = (gain_mag > 20'd32767) ? 16'h7FFF : gain_mag[SAMPLE_W-1:0];
    end
  end

  // configuration and run state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wave_q   <= WAVE_RST;
      semi_q   <= SEMI_RST;
      gain_q   <= GAIN_RST;
      count_q  <= COUNT_RST;
      phase_q  <= '0;
      idx_q    <= '0;
      lfsr_q   <= LFSR_SEED;
      done_q   <= 1'b0;
      silent_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_idx_i))
          CFG_WAVEFORM_TYPE:   wave_q  <= cfg_wdata_i[WAVE_W-1:0];
          CFG_SEMITONE_OFFSET: semi_q  <= cfg_wdata_i[SEMI_W-1:0];
          CFG_VOLUME_GAIN:     gain_q  <= cfg_wdata_i[GAIN_W-1:0];
          CFG_SAMPLE_COUNT:    count_q <= cfg_wdata_i[COUNT_W-1:0];
          default: ;
        endcase
      end
      if (cmd_i.start && restart_i) begin
        phase_q <= '0;
        idx_q   <= '0;
        done_q  <= 1'b0;
      end
      if (cmd_i.check) begin
        silent_q <= silent;
        if (silent) begin
          done_q <= 1'b1;
        end
      end
      if (cmd_i.update) begin
        phase_q <= phase_d;
        idx_q   <= idx_inc[COUNT_W-1:0];
        if (reseed) begin
          lfsr_q <= lfsr_next;
        end
        if (last) begin
          done_q <= 1'b1;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      prod_q <= PRW'(mul_a) * PRW'(mul_b);
    end
    if (cmd_i.rom_rd) begin
      rom_neg_q <= tab_idx[SB-1];
    end
    if (cmd_i.update) begin
      shp_neg_q <= shape_neg;
      shp_mag_q <= shape_mag;
      last_q    <= last;
    end
    if (cmd_i.out_ld) begin
      out_data_q <= silent_q ? '0 : sat_val;
      out_last_q <= silent_q ? 1'b0 : last_q;
    end
  end

  assign status_o.silent = silent;
  assign sample_o        = out_data_q;
  assign last_o          = out_last_q;

endmodule

`default_nettype wire

[sv/chiptune_waveform_oscillator.sv]
// an input transfer steps through check, noise, table, shape, gain and out states,
// or from check straight to out when silent; one sample at a time, set by the single
// shared multiplier that runs the cubed phase, triangle and gain in turn
// a finished sample waits in the output register while the next is accepted
// reset: async active low; registers to defaults, phase and index to zero
`timescale 1ns / 1ps
`default_nettype none

module chiptune_waveform_oscillator #(
  parameter int PhaseFracBits = cwo_pkg::PHASE_FRAC_BITS
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // input stream
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [cwo_pkg::IN_TDATA_W-1:0]  s_axis_tdata,  // [0] restart, rest zero
  // output stream
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [cwo_pkg::SAMPLE_W-1:0]    m_axis_tdata,  // [15:0] sample_value
  output logic                            m_axis_tlast,  // last_sample
  // configuration writes
  input  logic                            cfg_we_i,
  input  logic [cwo_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [cwo_pkg::CFG_DATA_W-1:0]  cfg_wdata_i
);
  import cwo_pkg::*;

  cmd_t    cmd;
  status_t status;

  // sequencer
  cwo_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // arithmetic and state
  cwo_dpath #(
    .PhaseFracBits (PhaseFracBits)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .restart_i   (s_axis_tdata[0]),
    .cmd_i       (cmd),
    .status_o    (status),
    .sample_o    (m_axis_tdata),
    .last_o      (m_axis_tlast)
  );

endmodule

`default_nettype wire

[sv/cwo_checker.sv]
// port-level checks of the chiptune waveform oscillator, bound to the top
// depends on chiptune_waveform_oscillator_assert.svh
`timescale 1ns / 1ps
`default_nettype none

`include "chiptune_waveform_oscillator_assert.svh"

module cwo_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  // one sample at a time: a transfer closes the input
  `CWO_ASSERT_NEXT(a_busy_after_in, s_axis_tvalid && s_axis_tready, (!s_axis_tready ##1 !s_axis_tready), "input reopened too early")

  // a new result is only presented after a busy cycle
  `CWO_ASSERT_NOW(a_out_from_busy, $rose(m_axis_tvalid), $past(!s_axis_tready), "result appeared while idle")

  // stalled result stays presented
  `CWO_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result dropped while stalled")

  // stalled result payload stays put
  `CWO_ASSERT_NEXT(a_out_stable, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata) && $stable(m_axis_tlast), "result changed while stalled")

endmodule

bind chiptune_waveform_oscillator cwo_checker u_cwo_checker (.*);

`default_nettype wire
